// ===== sv/mm_pkg.sv =====
// Shared types and constants of the fixed-point matrix multiplier.
`timescale 1ns / 1ps
package mm_pkg;

  // Configuration register port.
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS    = 2'd2;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 4'd3;

  // Q16.16 element and its full-precision product.
  localparam int VAL_W     = 32;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int FRAC_BITS = 16;

  typedef logic signed [VAL_W-1:0]  elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;

endpackage

// ===== sv/matrix_multiply.sv =====
// Top level of the fixed-point matrix multiplier, C = A * B.
`timescale 1ns / 1ps
// C = A * B in signed Q16.16. Elements arrive one per beat, A row-major and
// then B row-major, and are taken one per cycle while the input is open into
// two single-port stores; a size register of zero counts as one and one above
// MAX_DIM as MAX_DIM. The beat that completes B starts the calculation: a
// single multiply-accumulate unit takes one product per cycle while results
// are not stalled, and the input stays stalled until the last product is
// issued. C leaves via the read, product, accumulator and output registers.
// Each element of C is the exact sum of its products, shifted right by 16
// with rounding towards minus infinity and saturated to 32 bits; result_last
// marks the final one. The stores need no clearing after reset.
module matrix_multiply
  import mm_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 element_valid,
  output logic                 element_stall,
  input  elem_t                element_value,
  output logic                 result_valid,
  input  logic                 result_stall,
  output elem_t                result_value,
  output logic                 result_last
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int LW    = $clog2(2 * DEPTH + 1);
  localparam int ACC_W = PROD_W + $clog2(MAX_DIM);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_CALC = 1'b1;

  // Configuration registers and effective sizes.
  logic [CFG_W-1:0] a_rows, inner_dim, b_cols;
  logic [DW-1:0]    m, n, p;
  logic [2*DW-1:0]  mn, np;
  logic [LW-1:0]    a_len, total;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows    <= CFG_DIM_RESET;
      inner_dim <= CFG_DIM_RESET;
      b_cols    <= CFG_DIM_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_A_ROWS:    a_rows    <= cfg_data;
        CFG_INNER_DIM: inner_dim <= cfg_data;
        CFG_B_COLS:    b_cols    <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DW-1:0] e;
    if (v == '0) begin
      e = DW'(1);
    end else if (int'(v) > MAX_DIM) begin
      e = DW'(MAX_DIM);
    end else begin
      e = DW'(v);
    end
    return e;
  endfunction

  always_comb begin
    m     = eff_dim(a_rows);
    n     = eff_dim(inner_dim);
    p     = eff_dim(b_cols);
    mn    = m * n;
    np    = n * p;
    a_len = LW'(mn);
    total = LW'(mn) + LW'(np);
  end

  // Load sequencing.
  logic          state;
  logic [LW-1:0] load_count, pos, pos_inc, b_pos;
  logic          in_beat;
  logic          a_we, b_we;

  assign element_stall = (state != ST_LOAD);
  assign in_beat       = element_valid && !element_stall;

  always_comb begin
    pos     = (load_count >= total) ? '0 : load_count;
    pos_inc = pos + 1'b1;
    b_pos   = pos - a_len;
    a_we    = in_beat && (pos < a_len);
    b_we    = in_beat && !(pos < a_len);
  end

  // Product sequencer: i over rows of C, k over columns, j over the sum.
  logic          go, issue;
  logic [DW-1:0] i, k, j;
  logic [AW-1:0] a_idx, b_idx, a_base;
  logic          last_j, last_k, last_i;

  assign go     = !(result_valid && result_stall);
  assign issue  = (state == ST_CALC) && go;
  assign last_j = (j == n - DW'(1));
  assign last_k = (k == p - DW'(1));
  assign last_i = (i == m - DW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
    end else if (in_beat) begin
      if (pos_inc < total) begin
        load_count <= pos_inc;
      end else begin
        load_count <= '0;
        state      <= ST_CALC;
      end
    end else if (issue && last_j && last_k && last_i) begin
      state <= ST_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      i      <= '0;
      k      <= '0;
      j      <= '0;
      a_idx  <= '0;
      b_idx  <= '0;
      a_base <= '0;
    end else if (issue) begin
      if (!last_j) begin
        j     <= j + 1'b1;
        a_idx <= a_idx + 1'b1;
        b_idx <= b_idx + AW'(p);
      end else if (!last_k) begin
        j     <= '0;
        k     <= k + 1'b1;
        a_idx <= a_base;
        b_idx <= AW'(k) + 1'b1;
      end else begin
        j      <= '0;
        k      <= '0;
        i      <= i + 1'b1;
        a_base <= a_base + AW'(n);
        a_idx  <= a_base + AW'(n);
        b_idx  <= '0;
      end
    end
  end

  // Element stores with registered read ports.
  elem_t a_store [DEPTH];
  elem_t b_store [DEPTH];
  elem_t a_q, b_q;

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_store[pos[AW-1:0]] <= element_value;
    end
    if (issue) begin
      a_q <= a_store[a_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_store[b_pos[AW-1:0]] <= element_value;
    end
    if (issue) begin
      b_q <= b_store[b_idx];
    end
  end

  // Multiply-accumulate pipeline; the whole pipeline holds while a result
  // waits at the output.
  logic s1_valid, s1_first, s1_lastj, s1_lastc;
  logic s2_valid, s2_first, s2_lastj, s2_lastc;
  logic s3_done, s3_lastc;
  prod_t prod;
  logic signed [ACC_W-1:0] prod_ext, acc, acc_sh;
  elem_t sat_value;
  logic [ACC_W-VAL_W:0] acc_top;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_done      <= 1'b0;
      result_valid <= 1'b0;
    end else if (go) begin
      s1_valid     <= issue;
      s2_valid     <= s1_valid;
      s3_done      <= s2_valid && s2_lastj;
      result_valid <= s3_done;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_first <= (j == '0);
      s1_lastj <= last_j;
      s1_lastc <= last_j && last_k && last_i;
      prod     <= a_q * b_q;
      s2_first <= s1_first;
      s2_lastj <= s1_lastj;
      s2_lastc <= s1_lastc;
      s3_lastc <= s2_lastc;
      if (s2_valid) begin
        acc <= s2_first ? prod_ext : acc + prod_ext;
      end
      result_value <= sat_value;
      result_last  <= s3_lastc;
    end
  end

  // Arithmetic shift gives the floor; saturate when the top bits disagree.
  always_comb begin
    prod_ext = ACC_W'(prod);
    acc_sh   = acc >>> FRAC_BITS;
    acc_top  = acc_sh[ACC_W-1:VAL_W-1];
    if ((&acc_top) || !(|acc_top)) begin
      sat_value = acc_sh[VAL_W-1:0];
    end else if (acc_sh[ACC_W-1]) begin
      sat_value = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

endmodule

// ===== sv/mm_checker.sv =====
// Port checker for the matrix multiplier and its binding to the top level.
`timescale 1ns / 1ps
module mm_checker
  import mm_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  element_valid,
  input logic  element_stall,
  input logic  result_valid,
  input logic  result_stall,
  input elem_t result_value,
  input logic  result_last
);

  // A stalled result beat stays offered.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its payload.
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result_value) && $stable(result_last))
    else $error("result payload changed while stalled");

  // Out of reset the block takes elements and shows no result.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !element_stall && !result_valid)
    else $error("block not idle after reset");

  // The input only closes after the beat that completes B.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(element_stall) |-> $past(element_valid && !element_stall))
    else $error("input stalled without an accepted element");

endmodule

bind matrix_multiply mm_checker u_mm_checker (
  .clk           (clk),
  .rst           (rst),
  .element_valid (element_valid),
  .element_stall (element_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .result_value  (result_value),
  .result_last   (result_last)
);

// ===== dv/matrix_multiply_test.sv =====
// Self-checking testbench of the Q16.16 matrix multiplier, C = A * B.
`timescale 1ns / 1ps
module matrix_multiply_test;
  import mm_pkg::*;

  localparam int DIM_MAX        = 8;
  localparam int STORE_DEPTH    = DIM_MAX * DIM_MAX;
  localparam int ACC_W          = PROD_W + 8;
  localparam int ITEM_TARGET    = 210;
  localparam int SETTLE_CYCLES  = 16;
  localparam int TAIL_CYCLES    = 32;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic signed [ACC_W-1:0] Q_MAX = 2147483647;
  localparam logic signed [ACC_W-1:0] Q_MIN = -72'sd2147483648;

  typedef struct packed {
    elem_t value;
    logic  last;
  } c_elem_t;

  // One directed problem: every element of A holds a_fill, every one of B b_fill.
  typedef struct {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] inner;
    logic [CFG_W-1:0] cols;
    elem_t            a_fill;
    elem_t            b_fill;
    bit               typed;
    elem_t            c_value;
  } directed_case_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_A_ROWS;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 element_valid = 1'b0;
  logic                 element_stall;
  elem_t                element_value = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  elem_t                result_value;
  logic                 result_last;

  // Shadow copy of the block: both stores, the load position and the size registers.
  elem_t            a_copy[STORE_DEPTH];
  elem_t            b_copy[STORE_DEPTH];
  int unsigned      taken = 0;
  logic [CFG_W-1:0] size_reg[3] = '{CFG_DIM_RESET, CFG_DIM_RESET, CFG_DIM_RESET};

  c_elem_t     expected_c[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 82;
  int unsigned holds_asked = 0;
  int unsigned holds_started = 0;
  int unsigned hold_left = 0;

  elem_t corner_values[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};

  logic [CFG_W-1:0] extreme_sizes[4][3] = '{
    '{4'd1, 4'd15, 4'd1},
    '{4'd9, 4'd1,  4'd15},
    '{4'd8, 4'd2,  4'd8},
    '{4'd0, 4'd8,  4'd0}
  };

  directed_case_t directed_cases[9] = '{
    '{4'd1, 4'd1, 4'd1, 32'h0001_0000, 32'h0001_0000, 1'b1, 32'h0001_0000},
    '{4'd1, 4'd1, 4'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    '{4'd1, 4'd1, 4'd1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000},
    '{4'd1, 4'd1, 4'd1, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF},
    '{4'd1, 4'd1, 4'd1, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF},
    '{4'd1, 4'd1, 4'd1, 32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0000_0000},
    '{4'd0, 4'd0, 4'd0, 32'h0002_0000, 32'h0003_0000, 1'b1, 32'h0006_0000},
    '{4'd1, 4'd2, 4'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    '{4'd2, 4'd2, 4'd2, 32'h0001_8000, 32'hFFFE_0000, 1'b0, 32'h0000_0000}
  };

  matrix_multiply dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .element_valid (element_valid),
    .element_stall (element_stall),
    .element_value (element_value),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result_value  (result_value),
    .result_last   (result_last)
  );

  always #1 clk = ~clk;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return 32'(v);
  endfunction

  // Stores one accepted element; the element that completes B queues the whole of C.
  function automatic int take_element(input elem_t v);
    int unsigned m, n, p, a_len, total, pos, i, j, k;
    logic signed [ACC_W-1:0] acc;
    c_elem_t c;
    int produced;
    m = clamp_dim(size_reg[CFG_A_ROWS]);
    n = clamp_dim(size_reg[CFG_INNER_DIM]);
    p = clamp_dim(size_reg[CFG_B_COLS]);
    a_len = m * n;
    total = a_len + n * p;
    pos = (taken >= total) ? 0 : taken;
    if (pos < a_len) a_copy[pos % STORE_DEPTH] = v;
    else b_copy[(pos - a_len) % STORE_DEPTH] = v;
    if (pos + 1 < total) begin
      taken = pos + 1;
      return 0;
    end
    taken = 0;
    produced = 0;
    for (i = 0; i < m; i++) begin
      for (k = 0; k < p; k++) begin
        acc = '0;
        for (j = 0; j < n; j++) begin
          acc += a_copy[(i * n + j) % STORE_DEPTH] * b_copy[(j * p + k) % STORE_DEPTH];
        end
        // An arithmetic shift of the exact sum rounds towards minus infinity.
        acc = acc >>> FRAC_BITS;
        if (acc > Q_MAX) c.value = 32'h7FFF_FFFF;
        else if (acc < Q_MIN) c.value = 32'h8000_0000;
        else c.value = acc[VAL_W-1:0];
        c.last = (i == m - 1) && (k == p - 1);
        expected_c.push_back(c);
        produced++;
      end
    end
    return produced;
  endfunction

  function automatic elem_t random_element();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return corner_values[$urandom_range(0, 3)];
    // Values within plus or minus four keep most sums clear of saturation.
    if (pick < 4) return elem_t'($urandom_range(0, 32'h7_FFFF)) - elem_t'(32'h4_0000);
    return elem_t'($urandom());
  endfunction

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Waits until every element of C has come back and the block has gone quiet.
  task automatic settle();
    while (expected_c.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_sizes(input logic [CFG_W-1:0] rows, inner, cols);
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_A_ROWS;
    cfg_data     <= rows;
    size_reg[CFG_A_ROWS] = rows;
    @(negedge clk);
    cfg_index <= CFG_INNER_DIM;
    cfg_data  <= inner;
    size_reg[CFG_INNER_DIM] = inner;
    @(negedge clk);
    cfg_index <= CFG_B_COLS;
    cfg_data  <= cols;
    size_reg[CFG_B_COLS] = cols;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Offers one beat and holds it until the block takes it.
  task automatic offer_element(input elem_t v, output int produced);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      element_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    element_valid <= 1'b1;
    element_value <= v;
    do @(posedge clk); while (element_stall);
    produced = take_element(v);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic run_problem(input bit use_fill, input elem_t a_fill, b_fill,
                             output int produced);
    int unsigned n, a_len, b_len, e;
    n = clamp_dim(size_reg[CFG_INNER_DIM]);
    a_len = clamp_dim(size_reg[CFG_A_ROWS]) * n;
    b_len = n * clamp_dim(size_reg[CFG_B_COLS]);
    for (e = 0; e < a_len + b_len; e++) begin
      if (use_fill) offer_element((e < a_len) ? a_fill : b_fill, produced);
      else offer_element(random_element(), produced);
    end
    // The last beat must not stay offered once the block reopens its input.
    element_valid <= 1'b0;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : check_results
    c_elem_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_c.size() == 0) begin
        note_mismatch($sformatf("result %h with nothing outstanding", result_value));
      end else begin
        want = expected_c.pop_front();
        if (result_value !== want.value)
          note_mismatch($sformatf("result_value %h, expected %h", result_value, want.value));
        if (result_last !== want.last)
          note_mismatch($sformatf("result_last %b, expected %b", result_last, want.last));
      end
    end
  end

  // Random stall of the result side, overridden by a long hold-off when one is asked for.
  always @(negedge clk) begin : drive_result_stall
    if (hold_left == 0 && holds_started != holds_asked) begin
      holds_started++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    do begin
      @(posedge clk);
      if ((element_valid && !element_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end while (quiet < WATCHDOG_LIMIT);
    $display("No beat moved for %0d cycles", WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int produced;
    int unsigned phase, problems, r;
    c_elem_t c;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    for (r = 0; r < 9; r++) begin
      if (directed_cases[r].rows != size_reg[CFG_A_ROWS] ||
          directed_cases[r].inner != size_reg[CFG_INNER_DIM] ||
          directed_cases[r].cols != size_reg[CFG_B_COLS]) begin
        settle();
        set_sizes(directed_cases[r].rows, directed_cases[r].inner, directed_cases[r].cols);
      end
      run_problem(1'b1, directed_cases[r].a_fill, directed_cases[r].b_fill, produced);
      // The hand-worked value stands in for the predicted one; the result has not
      // yet been checked.
      if (directed_cases[r].typed && produced == 1) begin
        c = expected_c.pop_back();
        c.value = directed_cases[r].c_value;
        expected_c.push_back(c);
      end
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      if (items_sent < 100) begin
        send_idle_pct = 25;
        recv_idle_pct = 82;
      end else if (items_sent < 160) begin
        send_idle_pct = 82;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase % 2 == 0 && phase / 2 < 4) begin
        set_sizes(extreme_sizes[phase / 2][0], extreme_sizes[phase / 2][1],
                  extreme_sizes[phase / 2][2]);
        problems = 1;
      end else begin
        set_sizes(CFG_W'($urandom_range(0, 4)), CFG_W'($urandom_range(0, 4)),
                  CFG_W'($urandom_range(0, 4)));
        problems = $urandom_range(1, 3);
      end
      // Results are held back while further problems are offered, so the block backs up.
      if (phase == 1) begin
        holds_asked++;
        problems = 3;
      end
      repeat (problems) run_problem(1'b0, '0, '0, produced);
      phase++;
    end

    element_valid <= 1'b0;
    while (expected_c.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
